// File: rtl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg: shared types and constants for the 3x3 lbp operator
// Pixel and line-store word types, the window column type, pipeline control
// and the constant uniform-pattern lookup table.
// ----------------------------------------------------------------------------
package lbp_pkg;

	localparam int PIX_W        = 8;
	localparam int NEIGHBORS    = 8;
	localparam int CODE_COUNT   = 1 << NEIGHBORS;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_IDX_W    = 2;
	localparam int FRAME_W_W    = 11;
	localparam int FRAME_H_W    = 16;
	localparam int MIN_DIM      = 3;
	localparam int BORDER       = 2;
	localparam int MAX_CHANGES  = 2;

	localparam logic [FRAME_W_W-1:0] FRAME_W_RESET = 11'd640;
	localparam logic [FRAME_H_W-1:0] FRAME_H_RESET = 16'd480;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_UNIFORM_MODE = 2'd2
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;

	// one window column, top to bottom
	typedef struct packed {
		pix_t top;
		pix_t mid;
		pix_t bot;
	} col_t;

	// line store word: row two above and row just above
	typedef struct packed {
		pix_t upper;
		pix_t middle;
	} line_word_t;

	typedef struct packed {
		logic valid;
		logic emit;
		logic last;
	} stage_t;

	typedef logic [PIX_W-1:0] lut_t [CODE_COUNT];

	function automatic lut_t build_uniform_lut();
		lut_t lut;
		logic [CODE_COUNT-1:0] is_uniform;
		logic [NEIGHBORS-1:0] c;
		int rank;
		rank = 0;
		for (int code = 0; code < CODE_COUNT; code++) begin
			c = NEIGHBORS'(code);
			is_uniform[code] = ($countones(c ^ {c[0], c[NEIGHBORS-1:1]}) <= MAX_CHANGES);
			if (is_uniform[code]) begin
				lut[code] = PIX_W'(rank);
				rank++;
			end else begin
				lut[code] = '0;
			end
		end
		// everything else lands in the noise bin after the last rank
		for (int code = 0; code < CODE_COUNT; code++) begin
			if (!is_uniform[code]) begin
				lut[code] = PIX_W'(rank);
			end
		end
		return lut;
	endfunction

	localparam lut_t UNIFORM_LUT = build_uniform_lut();

endpackage

// File: rtl/lbp_ram.sv
// ----------------------------------------------------------------------------
// lbp_ram: generic simple dual-port ram
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lbp_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/lbp_cell.sv
// ----------------------------------------------------------------------------
// lbp_cell: one column of the 3x3 window
// Holds a pixel column, hands it to the left neighbor on every shift and
// compares its pixels against the window center.
// ----------------------------------------------------------------------------
module lbp_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          shift,
	input  lbp_pkg::col_t col_in,
	input  lbp_pkg::pix_t center,
	output lbp_pkg::col_t col_q,
	output logic [2:0]    ge
);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (shift) begin
			col_q <= col_in;
		end
	end

	// top, middle, bottom against the center
	assign ge = {col_q.top >= center, col_q.mid >= center, col_q.bot >= center};

endmodule

// File: rtl/lbp3x3_uniform_operator.sv
// ----------------------------------------------------------------------------
// lbp3x3_uniform_operator: 3x3 local binary pattern over a pixel stream
// Line stores in one ram, a three-cell window chain and an output skid stage.
//
//  channel   signals                                   direction
//  pixel     in_valid, in_ready, pixel                 request in
//  pattern   out_valid, out_ready, pattern, frame_last request out
//  config    cfg_write, cfg_index, cfg_data            write only
//
// one pixel per cycle while in_ready; pattern via stage 1, window, output register
// the single line-store ram port pair (one read, one write per cycle) sets the rate
// reset clears counters, window and config; line stores are not cleared
// in_ready drops only while the skid stage holds a second result
// ----------------------------------------------------------------------------
module lbp3x3_uniform_operator #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [7:0]                        pixel,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [7:0]                        pattern,
	output logic                              frame_last,
	input  logic                              cfg_write,
	input  logic [lbp_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lbp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int EW = (WW > lbp_pkg::FRAME_W_W) ? WW : lbp_pkg::FRAME_W_W;
	localparam int HW = lbp_pkg::FRAME_H_W;

	logic [lbp_pkg::FRAME_W_W-1:0] frame_width_q;
	logic [HW-1:0]                 frame_height_q;
	logic                          uniform_mode_q;

	logic [CW-1:0] column_count_q;
	logic [HW-1:0] row_count_q;

	logic adv, acc;
	logic [EW-1:0] w_eff, w_last, col_ext, col_cur;
	logic [HW-1:0] h_eff, h_last, row_cur;
	logic row_end, frame_end, emit;

	lbp_pkg::stage_t ctl_s1, ctl_s2;
	lbp_pkg::pix_t   pix_s1;
	logic [CW-1:0]   addr_s1;

	lbp_pkg::line_word_t rd_word, wr_word;
	lbp_pkg::col_t       col_new, col0, col1, col2;
	logic [2:0]          ge0, ge1, ge2;
	logic                shift;

	logic [7:0] raw_code, new_code;
	logic       new_v, out_take;

	logic       out_valid_q, frame_last_q, skid_v_q, skid_last_q;
	logic [7:0] pattern_q, skid_pattern_q;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= lbp_pkg::FRAME_W_RESET;
			frame_height_q <= lbp_pkg::FRAME_H_RESET;
			uniform_mode_q <= 1'b0;
		end else if (cfg_write) begin
			case (lbp_pkg::cfg_reg_t'(cfg_index))
				lbp_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data[lbp_pkg::FRAME_W_W-1:0];
				lbp_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data[HW-1:0];
				lbp_pkg::REG_UNIFORM_MODE: uniform_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign adv      = !skid_v_q;
	assign in_ready = adv;
	assign acc      = in_valid && adv;

	// position of the incoming pixel, clamped to the effective frame size
	always_comb begin
		w_eff = EW'(frame_width_q);
		if (w_eff < EW'(lbp_pkg::MIN_DIM)) begin
			w_eff = EW'(lbp_pkg::MIN_DIM);
		end else if (w_eff > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end
		w_last  = w_eff - EW'(1);
		col_ext = EW'(column_count_q);
		col_cur = (col_ext >= w_eff) ? w_last : col_ext;

		h_eff = (frame_height_q < HW'(lbp_pkg::MIN_DIM)) ? HW'(lbp_pkg::MIN_DIM)
			: frame_height_q;
		h_last  = h_eff - HW'(1);
		row_cur = (row_count_q >= h_eff) ? h_last : row_count_q;

		row_end   = (col_cur == w_last);
		frame_end = row_end && (row_cur == h_last);
		emit      = (row_cur >= HW'(lbp_pkg::BORDER)) && (col_cur >= EW'(lbp_pkg::BORDER));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (acc) begin
			if (frame_end) begin
				column_count_q <= '0;
				row_count_q    <= '0;
			end else if (row_end) begin
				column_count_q <= '0;
				row_count_q    <= row_cur + HW'(1);
			end else begin
				column_count_q <= CW'(col_cur + EW'(1));
				row_count_q    <= row_cur;
			end
		end
	end

	// stage 1: line store read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= acc;
			ctl_s1.emit  <= emit;
			ctl_s1.last  <= frame_end;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			pix_s1  <= pixel;
			addr_s1 <= col_cur[CW-1:0];
		end
	end

	assign shift          = adv && ctl_s1.valid;
	assign wr_word.upper  = rd_word.middle;
	assign wr_word.middle = pix_s1;

	lbp_ram #(
		.WIDTH ($bits(lbp_pkg::line_word_t)),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk   (clk),
		.we    (shift),
		.waddr (addr_s1),
		.wdata (wr_word),
		.re    (acc),
		.raddr (col_cur[CW-1:0]),
		.rdata (rd_word)
	);

	// window chain: new column enters on the right, moves left
	assign col_new.top = rd_word.upper;
	assign col_new.mid = rd_word.middle;
	assign col_new.bot = pix_s1;

	lbp_cell u_cell2 (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (shift),
		.col_in (col_new),
		.center (col1.mid),
		.col_q  (col2),
		.ge     (ge2)
	);

	lbp_cell u_cell1 (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (shift),
		.col_in (col2),
		.center (col1.mid),
		.col_q  (col1),
		.ge     (ge1)
	);

	lbp_cell u_cell0 (
		.clk    (clk),
		.arst_n (arst_n),
		.shift  (shift),
		.col_in (col1),
		.center (col1.mid),
		.col_q  (col0),
		.ge     (ge0)
	);

	// stage 2: window holds this pixel's neighborhood
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
		end
	end

	// clockwise from top-left down to left
	assign raw_code = {ge0[2], ge1[2], ge2[2], ge2[1], ge2[0], ge1[0], ge0[0], ge0[1]};
	assign new_code = uniform_mode_q ? lbp_pkg::UNIFORM_LUT[raw_code] : raw_code;
	assign new_v    = adv && ctl_s2.valid && ctl_s2.emit;
	assign out_take = out_valid_q && out_ready;

	// output register plus skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_v_q    <= 1'b0;
		end else if (skid_v_q) begin
			if (out_take) begin
				skid_v_q <= 1'b0;
			end
		end else if (new_v) begin
			if (out_valid_q && !out_ready) begin
				skid_v_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (out_take) begin
				pattern_q    <= skid_pattern_q;
				frame_last_q <= skid_last_q;
			end
		end else if (new_v) begin
			if (out_valid_q && !out_ready) begin
				skid_pattern_q <= new_code;
				skid_last_q    <= ctl_s2.last;
			end else begin
				pattern_q    <= new_code;
				frame_last_q <= ctl_s2.last;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign pattern    = pattern_q;
	assign frame_last = frame_last_q;

`ifndef NO_ASSERTIONS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_valid_q)
		else $error("skid stage holds a result while the output register is empty");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(column_count_q) < MAX_WIDTH)
		else $error("column counter beyond line store depth");

	a_accept_enters_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> ctl_s1.valid)
		else $error("accepted pixel missing from stage 1");
`endif

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for lbp3x3_uniform_operator
// Streams raster frames through the pixel port under random idling on both
// sides, mirrors line stores, window and frame counters to predict every
// pattern and its frame_last flag, and compares each result in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int LINE_MAX        = 1024;
	localparam int NOISE_BIN_CODES = 256;
	localparam int DRAIN_CYCLES    = 8;
	localparam int LONG_HOLD       = 300;
	localparam int RANDOM_PIXELS   = 350;
	localparam int CYCLE_LIMIT     = 1000000;

	typedef enum int {
		PIX_NOISE,
		PIX_NEAR_BASE,
		PIX_EXTREMES,
		PIX_RAMP
	} pixel_style_t;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} lbp_code_t;

	logic                           clk        = 1'b0;
	logic                           arst_n     = 1'b0;
	logic                           in_valid   = 1'b0;
	logic                           in_ready;
	logic [7:0]                     pixel      = '0;
	logic                           out_valid;
	logic                           out_ready  = 1'b0;
	logic [7:0]                     pattern;
	logic                           frame_last;
	logic                           cfg_write  = 1'b0;
	lbp_pkg::cfg_reg_t              cfg_index  = lbp_pkg::REG_FRAME_WIDTH;
	logic [lbp_pkg::CFG_DATA_W-1:0] cfg_data   = '0;

	// shadow of the block
	logic [10:0]    cur_width   = 11'd640;
	logic [15:0]    cur_height  = 16'd480;
	logic           cur_uniform = 1'b0;
	lbp_pkg::pix_t  row_two_up [LINE_MAX];
	lbp_pkg::pix_t  row_one_up [LINE_MAX];
	lbp_pkg::pix_t  win_pix [3][3];
	int unsigned    next_col = 0;
	int unsigned    next_row = 0;
	logic [7:0]     uniform_index [NOISE_BIN_CODES];

	lbp_code_t    expected_codes[$];
	int           error_count = 0;
	int unsigned  cycle_count = 0;
	int unsigned  pixels_sent = 0;
	bit           idling_on = 1'b1;
	bit           hold_off_pending = 1'b0;

	lbp3x3_uniform_operator #(
		.MAX_WIDTH(LINE_MAX)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel     (pixel),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pattern   (pattern),
		.frame_last(frame_last),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #10 clk = ~clk;

	function automatic bit is_uniform(input logic [7:0] code);
		int flips;
		int k;
		flips = 0;
		for (k = 0; k < 8; k++) begin
			flips += (code[k] != code[(k + 1) % 8]);
		end
		return flips <= 2;
	endfunction

	// one accepted pixel: slide the window, update line stores and counters
	function automatic void slide_window(input lbp_pkg::pix_t value);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		int i;
		bit row_end;
		bit frame_end;
		lbp_pkg::pix_t ctr;
		logic [7:0] code;
		lbp_code_t res;
		w = cur_width;
		if (w < 3) w = 3;
		if (w > LINE_MAX) w = LINE_MAX;
		h = cur_height;
		if (h < 3) h = 3;
		c = (next_col >= w) ? w - 1 : next_col;
		r = (next_row >= h) ? h - 1 : next_row;
		for (i = 0; i < 3; i++) begin
			win_pix[i][0] = win_pix[i][1];
			win_pix[i][1] = win_pix[i][2];
		end
		win_pix[0][2] = row_two_up[c];
		win_pix[1][2] = row_one_up[c];
		win_pix[2][2] = value;
		row_two_up[c] = row_one_up[c];
		row_one_up[c] = value;
		row_end = (c + 1 >= w);
		frame_end = row_end && (r + 1 >= h);
		if (r >= 2 && c >= 2) begin
			ctr = win_pix[1][1];
			// clockwise from top-left down to left
			code = {win_pix[0][0] >= ctr, win_pix[0][1] >= ctr, win_pix[0][2] >= ctr,
				win_pix[1][2] >= ctr, win_pix[2][2] >= ctr, win_pix[2][1] >= ctr,
				win_pix[2][0] >= ctr, win_pix[1][0] >= ctr};
			if (cur_uniform) code = uniform_index[code];
			res.code = code;
			res.last = frame_end;
			expected_codes.insert(expected_codes.size(), res);
		end
		if (frame_end) begin
			next_col = 0;
			next_row = 0;
		end else if (row_end) begin
			next_col = 0;
			next_row = r + 1;
		end else begin
			next_col = c + 1;
			next_row = r;
		end
	endfunction

	function automatic lbp_pkg::pix_t pick_pixel(input pixel_style_t style,
			input lbp_pkg::pix_t base);
		case (style)
			PIX_NOISE:     return lbp_pkg::pix_t'($urandom);
			PIX_NEAR_BASE: return base + lbp_pkg::pix_t'($urandom_range(0, 3));
			PIX_EXTREMES: begin
				case ($urandom_range(0, 2))
					0:       return 8'h00;
					1:       return 8'hFF;
					default: return base;
				endcase
			end
			default:       return lbp_pkg::pix_t'(next_col * 7 + next_row * 3 + base);
		endcase
	endfunction

	task automatic send_pixel(input lbp_pkg::pix_t value);
		int unsigned gap;
		if (idling_on && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 11);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		pixel <= value;
		do @(posedge clk); while (!in_ready);
		slide_window(value);
		pixels_sent++;
	endtask

	task automatic send_frame_rest(input pixel_style_t style, input lbp_pkg::pix_t base);
		do begin
			send_pixel(pick_pixel(style, base));
		end while (next_col != 0 || next_row != 0);
	endtask

	// all requests answered, then let border pixels still in flight settle
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_codes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [15:0] width_val, input logic [15:0] height_val,
			input logic mode);
		cfg_write <= 1'b1;
		cfg_index <= lbp_pkg::REG_FRAME_WIDTH;
		cfg_data <= width_val;
		@(posedge clk);
		cfg_index <= lbp_pkg::REG_FRAME_HEIGHT;
		cfg_data <= height_val;
		@(posedge clk);
		cfg_index <= lbp_pkg::REG_UNIFORM_MODE;
		cfg_data <= {15'($urandom), mode};
		@(posedge clk);
		cfg_write <= 1'b0;
		cur_width = width_val[10:0];
		cur_height = height_val;
		cur_uniform = mode;
	endtask

	task automatic run_random_frame();
		int unsigned width_val;
		int unsigned height_val;
		int unsigned pick;
		pixel_style_t style;
		lbp_pkg::pix_t base;
		pick = $urandom_range(0, 19);
		if (pick == 0) width_val = $urandom_range(0, 2);
		else if (pick < 4) width_val = $urandom_range(17, 64);
		else width_val = $urandom_range(3, 16);
		if ($urandom_range(0, 9) == 0) height_val = $urandom_range(0, 2);
		else height_val = $urandom_range(3, 7);
		style = pixel_style_t'($urandom_range(0, 3));
		base = lbp_pkg::pix_t'($urandom);
		wait_drained();
		configure(16'(width_val), 16'(height_val), 1'($urandom_range(0, 1)));
		send_frame_rest(style, base);
	endtask

	task automatic test_directed_codes();
		lbp_pkg::pix_t frames [4][9] = '{
			'{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
			'{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0},
			'{8'd200, 8'd50, 8'd200, 8'd50, 8'd100, 8'd50, 8'd200, 8'd50, 8'd200},
			'{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}
		};
		int f;
		int p;
		configure(16'd3, 16'd3, 1'b0);
		for (f = 0; f < 4; f++) begin
			// second pair goes through the uniform remap, alternating ring is noise
			if (f == 2) begin
				wait_drained();
				configure(16'd3, 16'd3, 1'b1);
			end
			for (p = 0; p < 9; p++) send_pixel(frames[f][p]);
		end
	endtask

	task automatic test_size_clamping();
		lbp_pkg::pix_t base;
		base = lbp_pkg::pix_t'($urandom);
		wait_drained();
		configure(16'd0, 16'd2, 1'b0);
		send_frame_rest(PIX_NOISE, 8'd0);
		// width field saturates at the line store size: first row ends there
		wait_drained();
		configure(16'hFFFF, 16'd0, 1'b1);
		repeat (LINE_MAX) send_pixel(pick_pixel(PIX_RAMP, base));
		// zero height acts as three, finish on a narrow row
		wait_drained();
		configure(16'd3, 16'd0, 1'b1);
		send_frame_rest(PIX_RAMP, base);
	endtask

	task automatic test_midframe_reconfig();
		wait_drained();
		configure(16'd3, 16'hFFFF, 1'b0);
		repeat (12) send_pixel(pick_pixel(PIX_NOISE, 8'd0));
		// row count already past the new height: frame closes at this row end
		wait_drained();
		configure(16'd3, 16'd3, 1'b0);
		send_frame_rest(PIX_NOISE, 8'd0);
		wait_drained();
		configure(16'd12, 16'd6, 1'b0);
		repeat (41) send_pixel(pick_pixel(PIX_NEAR_BASE, 8'd120));
		// column past the narrower width ends the row at once
		wait_drained();
		configure(16'd4, 16'd6, 1'b1);
		send_frame_rest(PIX_NEAR_BASE, 8'd120);
	endtask

	task automatic test_output_backpressure();
		wait_drained();
		configure(16'd16, 16'd6, 1'b0);
		hold_off_pending = 1'b1;
		send_frame_rest(PIX_NOISE, 8'd0);
	endtask

	task automatic test_random_frames();
		int unsigned start_count;
		start_count = pixels_sent;
		while (pixels_sent - start_count < RANDOM_PIXELS) run_random_frame();
	endtask

	task automatic test_streaming_no_gaps();
		wait_drained();
		idling_on = 1'b0;
		repeat (3) run_random_frame();
	endtask

	initial begin : main_sequence
		int rank;
		int code;
		rank = 0;
		for (code = 0; code < NOISE_BIN_CODES; code++) begin
			if (is_uniform(8'(code))) begin
				uniform_index[code] = 8'(rank);
				rank++;
			end
		end
		// every non-uniform code shares the bin after the last rank
		for (code = 0; code < NOISE_BIN_CODES; code++) begin
			if (!is_uniform(8'(code))) uniform_index[code] = 8'(rank);
		end
		foreach (row_two_up[i]) begin
			row_two_up[i] = '0;
			row_one_up[i] = '0;
		end
		foreach (win_pix[i, j]) win_pix[i][j] = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_codes();
		test_size_clamping();
		test_midframe_reconfig();
		test_output_backpressure();
		test_random_frames();
		test_streaming_no_gaps();

		wait_drained();
		repeat (4 * DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0) begin
			$display("PASS lbp3x3_uniform_operator");
		end else begin
			$display("FAIL lbp3x3_uniform_operator");
		end
		$finish;
	end

	initial begin : sink_pacing
		int unsigned gap;
		forever begin
			@(posedge clk);
			if (hold_off_pending) begin
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_off_pending = 1'b0;
				out_ready <= 1'b1;
			end else if (idling_on && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 11);
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : result_check
		lbp_code_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_codes.size() == 0) begin
				$display("%0t: unexpected pattern, expected none, got %0d last %0b",
					$time, pattern, frame_last);
				error_count++;
			end else begin
				want = expected_codes.pop_front();
				if (pattern !== want.code) begin
					$display("%0t: pattern expected %0d, got %0d",
						$time, want.code, pattern);
					error_count++;
				end
				if (frame_last !== want.last) begin
					$display("%0t: frame_last expected %0b, got %0b",
						$time, want.last, frame_last);
					error_count++;
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d patterns outstanding", $time,
				expected_codes.size());
			$display("FAIL lbp3x3_uniform_operator");
			$finish;
		end
	end

endmodule

// File: filelist.f
rtl/lbp_pkg.sv
rtl/lbp_ram.sv
rtl/lbp_cell.sv
rtl/lbp3x3_uniform_operator.sv
sim/testbench.sv
